// File: hw/rtl/sorted_knot_multiplicity_table_unit_macros.svh
// ============================================================================
// Sorted knot multiplicity table: assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ============================================================================
`ifndef SORTED_KNOT_MULTIPLICITY_TABLE_UNIT_MACROS_SVH
`define SORTED_KNOT_MULTIPLICITY_TABLE_UNIT_MACROS_SVH
`ifndef SYNTH
`define SKMT_ASSERT_ALW(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);
`define SKMT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SKMT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SKMT_ASSERT_ALW(lbl, expr, msg)
`define SKMT_ASSERT_IMP(lbl, ante, cons, msg)
`define SKMT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/skmt_pkg.sv
// ============================================================================
// skmt_pkg
// Sizes, codes and table entry type of the sorted knot multiplicity table.
// ============================================================================
package skmt_pkg;

    localparam int MAX_UNIQUE = 64;
    localparam int MULT_BITS  = 8;
    localparam int IDX_W      = $clog2(MAX_UNIQUE);
    localparam int CNT_W      = $clog2(MAX_UNIQUE + 1);
    localparam int TOT_W      = 14;
    localparam int UNIQ_W     = 7;
    localparam int VAL_W      = 32;
    localparam int TOL_W      = 31;

    localparam logic [MULT_BITS-1:0] MULT_MAX    = {MULT_BITS{1'b1}};
    localparam logic [TOT_W-1:0]     TOTAL_LIMIT = {TOT_W{1'b1}};

    typedef enum logic [1:0]
    {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_DUP    = 2'd2,
        OP_LOOKUP = 2'd3
    } op_t;

    typedef enum logic [2:0]
    {
        STAT_OK     = 3'd0,
        STAT_RANGE  = 3'd1,
        STAT_FULL   = 3'd2,
        STAT_BEYOND = 3'd3,
        STAT_SAT    = 3'd4
    } status_t;

    typedef struct packed
    {
        logic [MULT_BITS-1:0]    mult;
        logic signed [VAL_W-1:0] value;
    } entry_t;

endpackage

// File: hw/rtl/sorted_knot_multiplicity_table_unit.sv
// ============================================================================
// sorted_knot_multiplicity_table_unit
// Sorted table of unique Q16.16 knots with multiplicities, kept in one RAM.
// ============================================================================
// Usage:
//   s_axis: one transaction per operation. tuser carries op, tdata carries
//   knot_value and flat_index. m_axis: one result transaction per operation,
//   tuser carries status, tdata carries knot_out, total_count, unique_count.
//   cfg_we/cfg_wdata write the tolerance register; the user must write it
//   only while the block is idle, which the block itself does not enforce.
// Operation:
//   The table sits in a 64 x 40 bit RAM with a registered read. A scan
//   checks one entry per cycle; an insert that opens a gap moves one entry
//   per cycle through the single write port. An early-out (empty table,
//   index out of range) goes straight to the result; a raise or lookup
//   scans entries, and a new entry also moves the tail when needed and
//   writes it. Items are worked one at a time; the next item is
//   accepted in the cycle after a result is placed in the output register.
// Reset:
//   Table empty, counts zero, tolerance zero; RAM contents are not cleared.
// Stall:
//   A held result stays in the output register; work on the next item runs
//   on and waits in its final state until the output register frees.
// ============================================================================
`include "sorted_knot_multiplicity_table_unit_macros.svh"

module sorted_knot_multiplicity_table_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // tolerance[30:0]
    input  logic        cfg_we,
    input  logic [30:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // knot_value[31:0], flat_index[45:32], zero[47:46]
    input  logic [47:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // knot_out[31:0], total_count[45:32], unique_count[52:46], zero[55:53]
    output logic [55:0] m_axis_tdata,
    // status[2:0]
    output logic [2:0]  m_axis_tuser
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_PLACE,
        ST_DONE
    } state_t;

    localparam int IW = skmt_pkg::IDX_W;
    localparam int CW = skmt_pkg::CNT_W;
    localparam int TW = skmt_pkg::TOT_W;
    localparam int VW = skmt_pkg::VAL_W;

    skmt_pkg::entry_t mem_array [skmt_pkg::MAX_UNIQUE];
    skmt_pkg::entry_t rd_data_reg;
    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    logic [IW-1:0]    mem_raddr;
    skmt_pkg::entry_t mem_wdata;

    state_t                   state_reg, state_next;
    logic [skmt_pkg::TOL_W-1:0] tol_reg, tol_next;
    logic [CW-1:0]            used_reg, used_next;
    logic [TW-1:0]            total_reg, total_next;
    skmt_pkg::op_t            op_reg, op_next;
    logic signed [VW-1:0]     val_reg, val_next;
    logic [TW-1:0]            flat_reg, flat_next;
    logic [IW-1:0]            ptr_reg, ptr_next;
    logic [IW-1:0]            pos_reg, pos_next;
    logic [IW-1:0]            dst_reg, dst_next;
    logic [TW-1:0]            acc_reg, acc_next;
    skmt_pkg::status_t        stat_reg, stat_next;
    logic signed [VW-1:0]     found_reg, found_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [VW-1:0]     out_knot_reg, out_knot_next;
    skmt_pkg::status_t        out_stat_reg, out_stat_next;
    logic [TW-1:0]            out_total_reg, out_total_next;
    logic [CW-1:0]            out_used_reg, out_used_next;

    skmt_pkg::op_t        in_op;
    logic signed [VW-1:0] in_val;
    logic [TW-1:0]        in_flat;
    logic signed [33:0]   d_ab;
    logic signed [33:0]   d_ba;
    logic signed [33:0]   tol_ext;
    logic                 is_eq;
    logic                 is_gt;
    logic [TW:0]          acc_sum;
    logic                 is_hit;
    logic                 do_raise;
    logic                 do_place;
    logic [IW-1:0]        place_pos;
    logic                 is_full;
    logic                 out_free;

    assign in_op   = skmt_pkg::op_t'(s_axis_tuser);
    assign in_val  = $signed(s_axis_tdata[31:0]);
    assign in_flat = s_axis_tdata[45:32];

    assign d_ab    = 34'(rd_data_reg.value) - 34'(val_reg);
    assign d_ba    = 34'(val_reg) - 34'(rd_data_reg.value);
    assign tol_ext = $signed({3'b000, tol_reg});
    assign is_eq   = (d_ab <= tol_ext) && (d_ba <= tol_ext);
    assign is_gt   = rd_data_reg.value > val_reg;
    assign acc_sum = {1'b0, acc_reg} + (TW + 1)'(rd_data_reg.mult);
    assign is_hit  = acc_sum > {1'b0, flat_reg};
    assign is_full = (used_reg >= CW'(skmt_pkg::MAX_UNIQUE))
                     || (total_reg >= skmt_pkg::TOTAL_LIMIT);

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, skmt_pkg::UNIQ_W'(out_used_reg), out_total_reg,
                            out_knot_reg};
    assign m_axis_tuser  = out_stat_reg;

    always_comb
    begin
        state_next     = state_reg;
        tol_next       = cfg_we ? cfg_wdata : tol_reg;
        used_next      = used_reg;
        total_next     = total_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        flat_next      = flat_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        dst_next       = dst_reg;
        acc_next       = acc_reg;
        stat_next      = stat_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_knot_next  = out_knot_reg;
        out_stat_next  = out_stat_reg;
        out_total_next = out_total_reg;
        out_used_next  = out_used_reg;
        mem_we         = 1'b0;
        mem_waddr      = ptr_reg;
        mem_wdata      = rd_data_reg;
        mem_raddr      = ptr_reg;
        do_raise       = 1'b0;
        do_place       = 1'b0;
        place_pos      = ptr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                mem_raddr = '0;
                if (s_axis_tvalid)
                begin
                    op_next    = in_op;
                    val_next   = in_val;
                    flat_next  = in_flat;
                    acc_next   = '0;
                    found_next = '0;
                    stat_next  = skmt_pkg::STAT_OK;
                    ptr_next   = '0;
                    case (in_op)
                        skmt_pkg::OP_APPEND:
                        begin
                            if (used_reg == '0)
                            begin
                                do_place  = 1'b1;
                                place_pos = '0;
                            end
                            else
                            begin
                                mem_raddr  = IW'(used_reg - 1'b1);
                                ptr_next   = IW'(used_reg - 1'b1);
                                state_next = ST_SCAN;
                            end
                        end
                        skmt_pkg::OP_INSERT:
                        begin
                            if (used_reg == '0)
                            begin
                                stat_next  = skmt_pkg::STAT_BEYOND;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            if (in_flat >= total_reg)
                            begin
                                stat_next  = skmt_pkg::STAT_RANGE;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                mem_raddr = ptr_reg + 1'b1;
                case (op_reg)
                    skmt_pkg::OP_APPEND:
                    begin
                        if (is_eq)
                        begin
                            do_raise = 1'b1;
                        end
                        else
                        begin
                            do_place  = 1'b1;
                            place_pos = IW'(used_reg);
                        end
                    end
                    skmt_pkg::OP_INSERT:
                    begin
                        if (is_eq)
                        begin
                            do_raise = 1'b1;
                        end
                        else if (is_gt)
                        begin
                            do_place  = 1'b1;
                            place_pos = ptr_reg;
                        end
                        else if (ptr_reg == IW'(used_reg - 1'b1))
                        begin
                            stat_next  = skmt_pkg::STAT_BEYOND;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            ptr_next = ptr_reg + 1'b1;
                        end
                    end
                    skmt_pkg::OP_DUP:
                    begin
                        if (is_hit)
                        begin
                            do_raise = 1'b1;
                        end
                        else
                        begin
                            ptr_next = ptr_reg + 1'b1;
                            acc_next = TW'(acc_sum);
                        end
                    end
                    default:
                    begin
                        if (is_hit)
                        begin
                            found_next = rd_data_reg.value;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            ptr_next = ptr_reg + 1'b1;
                            acc_next = TW'(acc_sum);
                        end
                    end
                endcase
            end

            ST_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = dst_reg;
                mem_wdata = rd_data_reg;
                mem_raddr = dst_reg - IW'(2);
                if (dst_reg - 1'b1 == pos_reg)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    dst_next = dst_reg - 1'b1;
                end
            end

            ST_PLACE:
            begin
                mem_we          = 1'b1;
                mem_waddr       = pos_reg;
                mem_wdata.mult  = skmt_pkg::MULT_BITS'(1);
                mem_wdata.value = val_reg;
                used_next       = used_reg + 1'b1;
                total_next      = total_reg + 1'b1;
                stat_next       = skmt_pkg::STAT_OK;
                state_next      = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_knot_next  = found_reg;
                    out_stat_next  = stat_reg;
                    out_total_next = total_reg;
                    out_used_next  = used_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // raise the multiplicity of the entry just read, unless it is saturated or the total is full
        if (do_raise)
        begin
            state_next = ST_DONE;
            if (rd_data_reg.mult == skmt_pkg::MULT_MAX)
            begin
                stat_next = skmt_pkg::STAT_SAT;
            end
            else if (total_reg >= skmt_pkg::TOTAL_LIMIT)
            begin
                stat_next = skmt_pkg::STAT_FULL;
            end
            else
            begin
                mem_we         = 1'b1;
                mem_waddr      = ptr_reg;
                mem_wdata.mult = rd_data_reg.mult + 1'b1;
                total_next     = total_reg + 1'b1;
                stat_next      = skmt_pkg::STAT_OK;
            end
        end

        // open a new entry unless the table is full, moving the tail up first when needed
        if (do_place)
        begin
            pos_next = place_pos;
            if (is_full)
            begin
                stat_next  = skmt_pkg::STAT_FULL;
                state_next = ST_DONE;
            end
            else if (CW'(place_pos) == used_reg)
            begin
                state_next = ST_PLACE;
            end
            else
            begin
                dst_next   = IW'(used_reg);
                mem_raddr  = IW'(used_reg - 1'b1);
                state_next = ST_SHIFT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tol_reg       <= '0;
            used_reg      <= '0;
            total_reg     <= '0;
            op_reg        <= skmt_pkg::OP_APPEND;
            val_reg       <= '0;
            flat_reg      <= '0;
            ptr_reg       <= '0;
            pos_reg       <= '0;
            dst_reg       <= '0;
            acc_reg       <= '0;
            stat_reg      <= skmt_pkg::STAT_OK;
            found_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_knot_reg  <= '0;
            out_stat_reg  <= skmt_pkg::STAT_OK;
            out_total_reg <= '0;
            out_used_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            tol_reg       <= tol_next;
            used_reg      <= used_next;
            total_reg     <= total_next;
            op_reg        <= op_next;
            val_reg       <= val_next;
            flat_reg      <= flat_next;
            ptr_reg       <= ptr_next;
            pos_reg       <= pos_next;
            dst_reg       <= dst_next;
            acc_reg       <= acc_next;
            stat_reg      <= stat_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            out_knot_reg  <= out_knot_next;
            out_stat_reg  <= out_stat_next;
            out_total_reg <= out_total_next;
            out_used_reg  <= out_used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_array[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem_array[mem_raddr];
    end

    `SKMT_ASSERT_ALW(a_used_bound, used_reg <= CW'(skmt_pkg::MAX_UNIQUE),
        "entry count above table depth")
    `SKMT_ASSERT_ALW(a_total_ge_used, total_reg >= TW'(used_reg),
        "total count below entry count")
    `SKMT_ASSERT_IMP(a_we_busy, mem_we, (state_reg != ST_IDLE) && (state_reg != ST_DONE),
        "table write outside an operation")
    `SKMT_ASSERT_IMP(a_shift_above, state_reg == ST_SHIFT, dst_reg > pos_reg,
        "tail move reached insert position")
    `SKMT_ASSERT_NXT(a_place_grows, state_reg == ST_PLACE,
        used_reg == $past(used_reg) + 1'b1, "new entry did not raise entry count")

endmodule
